// ===== rtl/ocia_pkg.sv =====
// shared types and constants for the overflow-checked integer alu
package ocia_pkg;

	localparam int DATA_W          = 32;
	localparam int WIDE_W          = 2 * DATA_W;
	localparam int DIV_BITS        = 2;
	localparam int DIV_STAGES      = DATA_W / DIV_BITS;
	// input register, multiply register, divide stages, result register
	localparam int NSTG            = DIV_STAGES + 3;

	typedef enum logic [1:0] {
		MODE_ADD,
		MODE_SUB,
		MODE_MUL,
		MODE_DIV
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_OVF,
		ST_DIV0
	} status_t;

	typedef struct packed {
		mode_t                     mode;
		logic signed [DATA_W-1:0]  operand_a;
		logic signed [DATA_W-1:0]  operand_b;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0]  value;
		status_t                   status;
	} rsp_t;

	// work carried along the pipeline
	typedef struct packed {
		mode_t                     mode;
		logic signed [WIDE_W-1:0]  acc;
		logic [DATA_W-1:0]         rem;
		logic [DATA_W-1:0]         dq;
		logic [DATA_W-1:0]         dvs;
		logic                      neg;
		logic                      div0;
	} op_t;

	typedef struct packed {
		op_t                       op;
		logic signed [DATA_W-1:0]  a;
		logic signed [DATA_W-1:0]  b;
	} front_t;

endpackage

// ===== rtl/ocia_front.sv =====
// operand decode: add/subtract, magnitudes and sign for the divider
module ocia_front import ocia_pkg::*; (
	input  req_t   req,
	output front_t f
);

	logic [DATA_W:0]   sum_w;
	logic [DATA_W:0]   a_x;
	logic [DATA_W:0]   b_x;

	assign a_x = {req.operand_a[DATA_W-1], req.operand_a};
	assign b_x = {req.operand_b[DATA_W-1], req.operand_b};

	always_comb begin
		case (req.mode)
			MODE_SUB: sum_w = a_x - b_x;
			default:  sum_w = a_x + b_x;
		endcase
	end

	always_comb begin
		f          = '0;
		f.a        = req.operand_a;
		f.b        = req.operand_b;
		f.op.mode  = req.mode;
		f.op.acc   = {{(WIDE_W-DATA_W-1){sum_w[DATA_W]}}, sum_w};
		f.op.rem   = '0;
		f.op.dq    = req.operand_a[DATA_W-1] ? DATA_W'(-req.operand_a) : req.operand_a;
		f.op.dvs   = req.operand_b[DATA_W-1] ? DATA_W'(-req.operand_b) : req.operand_b;
		f.op.neg   = req.operand_a[DATA_W-1] ^ req.operand_b[DATA_W-1];
		f.op.div0  = (req.operand_b == '0);
	end

endmodule

// ===== rtl/ocia_mul.sv =====
// signed 32x32 multiply, product replaces the accumulator for multiply mode
module ocia_mul import ocia_pkg::*; (
	input  front_t f,
	output op_t    o
);

	logic signed [WIDE_W-1:0] prod;

	assign prod = $signed(f.a) * $signed(f.b);

	always_comb begin
		o = f.op;
		if (f.op.mode == MODE_MUL) begin
			o.acc = prod;
		end
	end

endmodule

// ===== rtl/ocia_div_step.sv =====
// restoring divide, DIV_BITS quotient bits per stage on magnitudes
module ocia_div_step import ocia_pkg::*; (
	input  op_t d,
	output op_t q
);

	always_comb begin
		logic [DATA_W:0]   t;
		logic [DATA_W-1:0] rem;
		logic [DATA_W-1:0] dq;
		rem = d.rem;
		dq  = d.dq;
		for (int i = 0; i < DIV_BITS; i++) begin
			t  = {rem, dq[DATA_W-1]};
			dq = {dq[DATA_W-2:0], 1'b0};
			if (t >= {1'b0, d.dvs}) begin
				rem   = DATA_W'(t - {1'b0, d.dvs});
				dq[0] = 1'b1;
			end else begin
				rem = t[DATA_W-1:0];
			end
		end
		q     = d;
		q.rem = rem;
		q.dq  = dq;
	end

endmodule

// ===== rtl/ocia_back.sv =====
// result select, quotient sign and overflow / divide-by-zero status
module ocia_back import ocia_pkg::*; (
	input  op_t  d,
	output rsp_t r
);

	logic [DATA_W:0] quo;
	logic            acc_ovf;

	assign quo     = d.neg ? (DATA_W+1)'(-{1'b0, d.dq}) : {1'b0, d.dq};
	assign acc_ovf = !((d.acc[WIDE_W-1:DATA_W-1] == '0) || (d.acc[WIDE_W-1:DATA_W-1] == '1));

	always_comb begin
		r.value  = d.acc[DATA_W-1:0];
		r.status = acc_ovf ? ST_OVF : ST_OK;
		if (d.mode == MODE_DIV) begin
			if (d.div0) begin
				r.value  = '0;
				r.status = ST_DIV0;
			end else begin
				r.value  = quo[DATA_W-1:0];
				r.status = (quo[DATA_W] != quo[DATA_W-1]) ? ST_OVF : ST_OK;
			end
		end
	end

endmodule

// ===== rtl/overflow_checked_int_alu_core.sv =====
// top level of the overflow-checked 32-bit signed add/subtract/multiply/divide unit
// Each req transaction (mode, operand_a, operand_b) yields exactly one rsp transaction
// (value, status), in order. The unit is a 19-stage pipeline that takes a new
// transaction every cycle unless rsp_stall has backed it up into req_stall. The divider
// resolves 2 quotient bits per stage over 16 stages; add, subtract and multiply ride the
// same stages so results never reorder. Value is the low 32 bits of the exact result
// (two's complement wrap); status is ok, overflow when the exact result leaves the
// signed 32-bit range (including most-negative divided by minus one), or divide-by-zero
// with a value of zero. Every stage holds its transaction only while the stage ahead is
// full and held, so bubbles close up under rsp_stall and req_stall rises only once the
// whole pipeline is full.
module overflow_checked_int_alu_core import ocia_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	// per-stage occupancy and the ready chain running back from the output
	logic [NSTG-1:0] vld_q;
	logic [NSTG:0]   rdy;

	// stage registers
	front_t front_s1;
	op_t    mul_s2;
	op_t    div_sd [DIV_STAGES];
	rsp_t   res_s19;

	// stage logic outputs
	front_t front_d;
	op_t    mul_d;
	op_t    div_d [DIV_STAGES];
	rsp_t   res_d;

	// a stage may load when it is empty or its content moves on
	always_comb begin
		rdy[NSTG] = !rsp_stall;
		for (int i = NSTG - 1; i >= 0; i--) begin
			rdy[i] = !vld_q[i] || rdy[i+1];
		end
	end

	assign req_stall = !rdy[0];
	assign rsp_valid = vld_q[NSTG-1];
	assign rsp       = res_s19;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) begin
				vld_q[0] <= req_valid;
			end
			for (int i = 1; i < NSTG; i++) begin
				if (rdy[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	// stage 1: operand decode, add and subtract
	ocia_front u_front (
		.req (req),
		.f   (front_d)
	);

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			front_s1 <= front_d;
		end
	end

	// stage 2: multiplier
	ocia_mul u_mul (
		.f (front_s1),
		.o (mul_d)
	);

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			mul_s2 <= mul_d;
		end
	end

	// stages 3 to 18: divider, most significant quotient bits first
	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		ocia_div_step u_step (
			.d ((k == 0) ? mul_s2 : div_sd[(k == 0) ? 0 : k-1]),
			.q (div_d[k])
		);

		always_ff @(posedge clk) begin
			if (rdy[k+2]) begin
				div_sd[k] <= div_d[k];
			end
		end
	end

	// stage 19: result and status, held here while rsp_stall is high
	ocia_back u_back (
		.d (div_sd[DIV_STAGES-1]),
		.r (res_d)
	);

	always_ff @(posedge clk) begin
		if (rdy[NSTG-1]) begin
			res_s19 <= res_d;
		end
	end

endmodule

// ===== rtl/ocia_checker.sv =====
// port-level checks for the overflow-checked integer alu, bound to the top level
module ocia_checker import ocia_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// a held request stays put
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_stall |=> req_valid && $stable(req))
		else $error("req changed while stalled");

	// a held result stays put
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("rsp changed while stalled");

	// divide by zero always reports a zero value
	a_div0_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_DIV0) |-> (rsp.value == '0))
		else $error("divide-by-zero with nonzero value");

	// a free-running output never backs up the input
	a_no_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_stall |-> !req_stall)
		else $error("req stalled while rsp is free");

	// an empty output stage means room in the pipeline
	a_empty_out: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> !req_stall)
		else $error("req stalled with empty output");

endmodule

bind overflow_checked_int_alu_core ocia_checker u_ocia_checker (.*);
